### rtl/poq_pkg.sv
`timescale 1ns / 1ps
// poq_pkg: shared types and codes for the priority ordered queue
// used by poq_cell, priority_ordered_queue_top and poq_checker
package poq_pkg;

  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned IdW           = 8;
  localparam int unsigned PriW          = 16;
  localparam int unsigned OccW          = 5;

  typedef enum logic [2:0] {
    K_ADD_SORTED = 3'd0,
    K_ADD_HEAD   = 3'd1,
    K_ADD_TAIL   = 3'd2,
    K_REM_HEAD   = 3'd3,
    K_REM_TAIL   = 3'd4,
    K_REM_ID     = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_FULL     = 2'd2,
    ST_NOTFOUND = 2'd3
  } status_e;

  // how a cell locates the slot an operation acts on
  typedef enum logic [1:0] {
    PM_SEARCH = 2'd0,
    PM_HEAD   = 2'd1,
    PM_TAIL   = 2'd2,
    PM_LAST   = 2'd3
  } pos_mode_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_CMP   = 3'b010,
    S_APPLY = 3'b100
  } state_e;

  typedef struct packed {
    logic [IdW-1:0]         id;
    logic signed [PriW-1:0] pri;
  } entry_t;

  typedef struct packed {
    logic      cmp_en;
    logic      upd_en;
    logic      insert;
    pos_mode_e mode;
    entry_t    key;
  } ctrl_t;

endpackage

### rtl/poq_cell.sv
`timescale 1ns / 1ps
// poq_cell: one queue slot, compares against the request and shifts with its neighbors
// depends on poq_pkg
module poq_cell
  import poq_pkg::*;
#(
  parameter int unsigned CntW = 5,
  parameter int unsigned Idx  = 0
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_t           ctrl_i,
  input  logic [CntW-1:0] count_i,
  input  logic            ahead_i,
  input  entry_t          left_i,
  input  entry_t          right_i,
  output entry_t          entry_o,
  output logic            hit_o,
  output entry_t          taken_o
);

  localparam logic [CntW-1:0] IdxC = CntW'(Idx);

  entry_t entry_q, entry_d;
  logic   hit_q, hit_d;
  logic   in_use, is_pos, is_after;

  assign in_use = IdxC < count_i;

  always_comb begin
    hit_d = hit_q;
    if (ctrl_i.cmp_en) begin
      if (ctrl_i.insert) begin
        hit_d = in_use && (ctrl_i.key.pri < entry_q.pri);
      end else begin
        hit_d = in_use && (ctrl_i.key.id == entry_q.id);
      end
    end
  end

  always_comb begin
    unique case (ctrl_i.mode)
      PM_SEARCH: begin
        is_pos   = hit_q && !ahead_i;
        is_after = ahead_i;
      end
      PM_HEAD: begin
        is_pos   = (IdxC == '0);
        is_after = (IdxC != '0);
      end
      PM_TAIL: begin
        is_pos   = (IdxC == count_i);
        is_after = (IdxC > count_i);
      end
      PM_LAST: begin
        is_pos   = (IdxC + CntW'(1) == count_i);
        is_after = (IdxC >= count_i);
      end
      default: begin
        is_pos   = 1'b0;
        is_after = 1'b0;
      end
    endcase
  end

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.upd_en) begin
      if (ctrl_i.insert) begin
        if (is_pos) begin
          entry_d = ctrl_i.key;
        end else if (is_after) begin
          entry_d = left_i;
        end
      end else if (is_pos || is_after) begin
        entry_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hit_q <= 1'b0;
    end else begin
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  assign hit_o   = hit_q;
  assign taken_o = is_pos ? entry_q : '0;

endmodule

### rtl/priority_ordered_queue_top.sv
`timescale 1ns / 1ps
// priority_ordered_queue_top: bounded ordered queue built from a chain of poq_cell slots
// depends on poq_pkg and poq_cell
//
// Each operation proceeds in order: the transfer latches the request, in S_CMP
// every cell compares its entry with the request in parallel, and in S_APPLY, once the
// output register is free, the chain resolves the first matching slot and shifts
// entries one slot toward head or tail while the result is written to the output
// register. A new request is taken once the block is back in idle, even while the
// previous result still waits for out_ready_i. Occupancy is reported modulo 32.
module priority_ordered_queue_top
  import poq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [2:0]             kind_i,
  input  logic [IdW-1:0]         node_id_i,
  input  logic signed [PriW-1:0] priority_req_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [1:0]             status_o,
  output logic [IdW-1:0]         taken_id_o,
  output logic signed [PriW-1:0] taken_priority_o,
  output logic [OccW-1:0]        occupancy_o
);

  localparam int unsigned CntW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CntW-1:0] Full = CntW'(QUEUE_DEPTH);

  state_e          state_q, state_d;
  logic [2:0]      kind_q;
  entry_t          key_q;
  logic [CntW-1:0] count_q, count_d;

  logic            out_valid_q;
  logic [1:0]      status_q, status_d;
  entry_t          taken_q, taken_d;
  logic [OccW-1:0] occ_q;

  ctrl_t                  ctrl;
  logic [QUEUE_DEPTH-1:0] hits;
  entry_t                 cells   [QUEUE_DEPTH];
  entry_t                 takens  [QUEUE_DEPTH];
  logic                   found, out_free, op_ok, is_add, is_rem;
  logic                   in_xfer, apply;
  entry_t                 taken_or;

  assign in_ready_o = (state_q == S_IDLE);
  assign in_xfer    = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign apply      = (state_q == S_APPLY) && out_free;
  assign found      = |hits;
  assign is_add     = (kind_q == K_ADD_SORTED) || (kind_q == K_ADD_HEAD)
                   || (kind_q == K_ADD_TAIL);
  assign is_rem     = (kind_q == K_REM_HEAD) || (kind_q == K_REM_TAIL)
                   || (kind_q == K_REM_ID);

  always_comb begin
    status_d = ST_OK;
    op_ok    = 1'b0;
    if (is_add) begin
      if (count_q >= Full) begin
        status_d = ST_FULL;
      end else begin
        op_ok = 1'b1;
      end
    end else if (is_rem) begin
      if (count_q == '0) begin
        status_d = ST_EMPTY;
      end else if ((kind_q == K_REM_ID) && !found) begin
        status_d = ST_NOTFOUND;
      end else begin
        op_ok = 1'b1;
      end
    end
  end

  always_comb begin
    ctrl.cmp_en = (state_q == S_CMP);
    ctrl.upd_en = apply && op_ok;
    ctrl.insert = is_add || (kind_q == K_ADD_SORTED);
    ctrl.key    = key_q;
    unique case (kind_q)
      K_ADD_SORTED: ctrl.mode = found ? PM_SEARCH : PM_TAIL;
      K_ADD_HEAD:   ctrl.mode = PM_HEAD;
      K_ADD_TAIL:   ctrl.mode = PM_TAIL;
      K_REM_HEAD:   ctrl.mode = PM_HEAD;
      K_REM_TAIL:   ctrl.mode = PM_LAST;
      K_REM_ID:     ctrl.mode = PM_SEARCH;
      default:      ctrl.mode = PM_HEAD;
    endcase
  end

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    localparam logic [QUEUE_DEPTH-1:0] LowMask =
      (QUEUE_DEPTH'(1) << i) - QUEUE_DEPTH'(1);
    entry_t left, right;
    logic   ahead;

    assign ahead = |(hits & LowMask);
    assign left  = (i == 0) ? '0 : cells[(i == 0) ? 0 : i - 1];
    assign right = (i == QUEUE_DEPTH - 1) ? '0
                 : cells[(i == QUEUE_DEPTH - 1) ? i : i + 1];

    poq_cell #(
      .CntW (CntW),
      .Idx  (i)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .count_i (count_q),
      .ahead_i (ahead),
      .left_i  (left),
      .right_i (right),
      .entry_o (cells[i]),
      .hit_o   (hits[i]),
      .taken_o (takens[i])
    );
  end

  always_comb begin
    taken_or = '0;
    for (int unsigned i = 0; i < QUEUE_DEPTH; i++) begin
      taken_or = taken_or | takens[i];
    end
  end

  always_comb begin
    taken_d = (is_rem && op_ok) ? taken_or : '0;
    count_d = count_q;
    if (apply && op_ok) begin
      count_d = is_add ? count_q + CntW'(1) : count_q - CntW'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_xfer) state_d = S_CMP;
      S_CMP:   state_d = S_APPLY;
      S_APPLY: if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (apply) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      kind_q     <= kind_i;
      key_q.id   <= node_id_i;
      key_q.pri  <= priority_req_i;
    end
    if (apply) begin
      status_q <= status_d;
      taken_q  <= taken_d;
      occ_q    <= OccW'(count_d);
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = status_q;
  assign taken_id_o       = taken_q.id;
  assign taken_priority_o = taken_q.pri;
  assign occupancy_o      = occ_q;

endmodule

### rtl/poq_checker.sv
`timescale 1ns / 1ps
// poq_checker: port-level checks for priority_ordered_queue_top, bound to the top level
// depends on poq_pkg
module poq_checker
  import poq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef
) (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   in_valid_i,
  input logic                   in_ready_o,
  input logic                   out_valid_o,
  input logic                   out_ready_i,
  input logic [1:0]             status_o,
  input logic [IdW-1:0]         taken_id_o,
  input logic signed [PriW-1:0] taken_priority_o,
  input logic [OccW-1:0]        occupancy_o
);

  localparam logic [OccW-1:0] FullOcc = OccW'(QUEUE_DEPTH);

  // one request in flight at a time
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("input ready right after a transfer");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(taken_id_o) && $stable(taken_priority_o) && $stable(occupancy_o))
    else $error("result changed while stalled");

  // failed operations take nothing
  a_fail_no_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> (taken_id_o == '0) && (taken_priority_o == '0))
    else $error("failed operation reports a taken entry");

  a_empty_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_EMPTY) |-> (occupancy_o == '0))
    else $error("empty status with nonzero occupancy");

  a_full_occ: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL) |-> (occupancy_o == FullOcc))
    else $error("full status with wrong occupancy");

endmodule

bind priority_ordered_queue_top poq_checker #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_poq_checker (.*);
